// ===== hw/rtl/gif_pixel_unpack_and_interlace_macros.svh =====
// Assertion helpers for the RTL of the GIF pixel unpacker (used by gifpu_ser).
`ifndef GIF_PIXEL_UNPACK_AND_INTERLACE_MACROS_SVH
`define GIF_PIXEL_UNPACK_AND_INTERLACE_MACROS_SVH

// Same-cycle implication, masked while reset is held.
`define GIFPU_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is held.
`define GIFPU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gifpu_pkg.sv =====
package gifpu_pkg;

  localparam int LANES  = 8;
  localparam int LANE_W = $clog2(LANES);

  localparam int PIX_W = 8;
  localparam int DIM_W = 16;
  localparam int BPP_W = 4;

  localparam int APB_DW = 32;
  localparam int APB_AW = 5;

  // Reset values of the registers
  localparam logic [BPP_W-1:0] BPP_RST    = 4'd8;
  localparam logic [DIM_W-1:0] WIDTH_RST  = 16'd1;
  localparam logic [DIM_W-1:0] HEIGHT_RST = 16'd1;

  // Interlace is honoured only from this height up
  localparam logic [DIM_W-1:0] MIN_IL_HEIGHT = 16'd5;

  // Row step and first row of each interlace pass
  localparam logic [3:0] STEP_P0 = 4'd8;
  localparam logic [3:0] STEP_P1 = 4'd8;
  localparam logic [3:0] STEP_P2 = 4'd4;
  localparam logic [3:0] STEP_P3 = 4'd2;
  localparam logic [DIM_W-1:0] START_P1 = 16'd4;
  localparam logic [DIM_W-1:0] START_P2 = 16'd2;
  localparam logic [DIM_W-1:0] START_P3 = 16'd1;

  // Pixels per byte for each depth
  localparam logic [LANE_W:0]   PER_BYTE_1 = 4'd8;
  localparam logic [LANE_W:0]   PER_BYTE_4 = 4'd2;
  localparam logic [LANE_W:0]   PER_BYTE_8 = 4'd1;

  typedef enum logic [1:0] {
    MODE_1BPP,
    MODE_4BPP,
    MODE_8BPP
  } mode_t;

  typedef enum logic [1:0] {
    PASS_0,
    PASS_1,
    PASS_2,
    PASS_3
  } pass_t;

  typedef enum logic [2:0] {
    REG_BPP         = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_TRANS_ON    = 3'd3,
    REG_TRANS_IDX   = 3'd4,
    REG_OPAQUE_IDX  = 3'd5,
    REG_INTERLACED  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [BPP_W-1:0] bpp;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             trans_on;
    logic [PIX_W-1:0] trans_idx;
    logic [PIX_W-1:0] opaque_idx;
    logic             interlaced;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             row_end;
    logic             active;
  } lane_out_t;

  typedef struct packed {
    logic [LANES-1:0][PIX_W-1:0] pix;
    logic [DIM_W-1:0]            row;
    logic [LANE_W-1:0]           last_idx;
    logic                        row_done;
  } batch_t;

  function automatic mode_t bpp_mode(input logic [BPP_W-1:0] bpp);
    mode_t m;
    if (bpp == 4'd1) begin
      m = MODE_1BPP;
    end else if (bpp == 4'd4) begin
      m = MODE_4BPP;
    end else begin
      m = MODE_8BPP;
    end
    return m;
  endfunction

  function automatic logic [LANE_W:0] per_byte(input mode_t m);
    logic [LANE_W:0] n;
    unique case (m)
      MODE_1BPP: n = PER_BYTE_1;
      MODE_4BPP: n = PER_BYTE_4;
      default:   n = PER_BYTE_8;
    endcase
    return n;
  endfunction

endpackage

// ===== hw/rtl/gifpu_if.sv =====
interface gifpu_in_if;
  logic                           valid;
  logic                           ready;
  logic [gifpu_pkg::PIX_W-1:0]    data_byte;
  logic [gifpu_pkg::LANES-1:0]    mask_bits;
  logic                           mask_present;

  modport source (output valid, data_byte, mask_bits, mask_present, input ready);
  modport sink   (input valid, data_byte, mask_bits, mask_present, output ready);
endinterface

interface gifpu_out_if;
  logic                           valid;
  logic                           ready;
  logic [gifpu_pkg::PIX_W-1:0]    pixel_index;
  logic [gifpu_pkg::DIM_W-1:0]    row_number;
  logic                           row_done;
  logic                           last_of_byte;

  modport source (output valid, pixel_index, row_number, row_done, last_of_byte,
                  input ready);
  modport sink   (input valid, pixel_index, row_number, row_done, last_of_byte,
                  output ready);
endinterface

// ===== hw/rtl/gif_pixel_unpack_and_interlace.sv =====
// GIF pixel unpacker with sequential or four-pass interlaced row numbering.
// in_chan carries one request per packed row byte (data_byte, mask_bits,
// mask_present); out_chan gives one pixel per handshake with its row number,
// a row_done flag on the last pixel of a row and last_of_byte on the final
// pixel produced by the byte. Registers sit on the APB port, byte addresses
// 0 to 24; write them only while no byte is in flight.
// Eight lanes unpack and substitute all pixels of a byte at once; a merge
// stage cuts the byte at the row end and loads a one-byte result buffer.
// Latency: the first pixel of a byte is valid the cycle after it is taken.
// Throughput: one pixel per cycle while out_chan.ready is high. A byte gives
// 8 pixels at 1 bit per pixel, 2 at 4 bits, 1 at 8 bits, fewer where the row
// ends inside the byte. The next byte is taken in the cycle the previous
// byte's last pixel is taken, so bytes stream without gaps.
// Reset: registers return to their defaults (8 bits per pixel, width and
// height 1), column, row and pass go to zero and the buffer empties.
// Stall: with out_chan.ready low the current pixel holds, and in_chan.ready
// stays low until the buffered byte has fully drained.
module gif_pixel_unpack_and_interlace (
  input  logic                          clk,
  input  logic                          rst_n,
  gifpu_in_if.sink                      in_chan,
  gifpu_out_if.source                   out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gifpu_pkg::APB_AW-1:0]  paddr,
  input  logic [gifpu_pkg::APB_DW-1:0]  pwdata,
  output logic [gifpu_pkg::APB_DW-1:0]  prdata,
  output logic                          pready
);

  gifpu_pkg::cfg_t   cfg;
  gifpu_pkg::batch_t batch;
  logic              in_ready;
  logic              accept;

  assign in_chan.ready = in_ready;
  assign accept        = in_chan.valid && in_ready;

  gifpu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  gifpu_merge u_merge (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .accept       (accept),
    .data_byte    (in_chan.data_byte),
    .mask_bits    (in_chan.mask_bits),
    .mask_present (in_chan.mask_present),
    .batch        (batch)
  );

  gifpu_ser u_ser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_chan.valid),
    .in_ready     (in_ready),
    .batch_in     (batch),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .pixel_index  (out_chan.pixel_index),
    .row_number   (out_chan.row_number),
    .row_done     (out_chan.row_done),
    .last_of_byte (out_chan.last_of_byte)
  );

endmodule

// ===== hw/rtl/gifpu_cfg.sv =====
module gifpu_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gifpu_pkg::APB_AW-1:0]  paddr,
  input  logic [gifpu_pkg::APB_DW-1:0]  pwdata,
  output logic [gifpu_pkg::APB_DW-1:0]  prdata,
  output logic                          pready,
  output gifpu_pkg::cfg_t               cfg
);

  gifpu_pkg::cfg_t     cfg_r;
  gifpu_pkg::reg_idx_t idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = gifpu_pkg::reg_idx_t'(paddr[gifpu_pkg::APB_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bpp        <= gifpu_pkg::BPP_RST;
      cfg_r.width      <= gifpu_pkg::WIDTH_RST;
      cfg_r.height     <= gifpu_pkg::HEIGHT_RST;
      cfg_r.trans_on   <= 1'b0;
      cfg_r.trans_idx  <= '0;
      cfg_r.opaque_idx <= '0;
      cfg_r.interlaced <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        gifpu_pkg::REG_BPP:        cfg_r.bpp        <= pwdata[gifpu_pkg::BPP_W-1:0];
        gifpu_pkg::REG_WIDTH:      cfg_r.width      <= pwdata[gifpu_pkg::DIM_W-1:0];
        gifpu_pkg::REG_HEIGHT:     cfg_r.height     <= pwdata[gifpu_pkg::DIM_W-1:0];
        gifpu_pkg::REG_TRANS_ON:   cfg_r.trans_on   <= pwdata[0];
        gifpu_pkg::REG_TRANS_IDX:  cfg_r.trans_idx  <= pwdata[gifpu_pkg::PIX_W-1:0];
        gifpu_pkg::REG_OPAQUE_IDX: cfg_r.opaque_idx <= pwdata[gifpu_pkg::PIX_W-1:0];
        gifpu_pkg::REG_INTERLACED: cfg_r.interlaced <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      gifpu_pkg::REG_BPP:        prdata = gifpu_pkg::APB_DW'(cfg_r.bpp);
      gifpu_pkg::REG_WIDTH:      prdata = gifpu_pkg::APB_DW'(cfg_r.width);
      gifpu_pkg::REG_HEIGHT:     prdata = gifpu_pkg::APB_DW'(cfg_r.height);
      gifpu_pkg::REG_TRANS_ON:   prdata = gifpu_pkg::APB_DW'(cfg_r.trans_on);
      gifpu_pkg::REG_TRANS_IDX:  prdata = gifpu_pkg::APB_DW'(cfg_r.trans_idx);
      gifpu_pkg::REG_OPAQUE_IDX: prdata = gifpu_pkg::APB_DW'(cfg_r.opaque_idx);
      gifpu_pkg::REG_INTERLACED: prdata = gifpu_pkg::APB_DW'(cfg_r.interlaced);
      default:                   prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/gifpu_lane.sv =====
module gifpu_lane #(
  parameter int LANE = 0
) (
  input  logic [gifpu_pkg::PIX_W-1:0] data_byte,
  input  logic                        mask_bit,
  input  logic                        masked_row,
  input  gifpu_pkg::mode_t            mode,
  input  logic [gifpu_pkg::DIM_W-1:0] column,
  input  gifpu_pkg::cfg_t             cfg,
  output gifpu_pkg::lane_out_t        lane_out
);

  localparam int BIT_POS = gifpu_pkg::LANES - 1 - LANE;

  logic [gifpu_pkg::PIX_W-1:0] raw;
  logic [gifpu_pkg::PIX_W-1:0] pix;
  logic                        active;
  logic                        row_end;
  logic [gifpu_pkg::DIM_W:0]   col_next;

  // Pick this lane's pixel, first pixel from the high bits
  always_comb begin
    unique case (mode)
      gifpu_pkg::MODE_1BPP: raw = gifpu_pkg::PIX_W'(data_byte[BIT_POS]);
      gifpu_pkg::MODE_4BPP: raw = (LANE == 0) ? gifpu_pkg::PIX_W'(data_byte[7:4])
                                              : gifpu_pkg::PIX_W'(data_byte[3:0]);
      default:              raw = data_byte;
    endcase
  end

  always_comb begin
    unique case (mode)
      gifpu_pkg::MODE_1BPP: active = 1'b1;
      gifpu_pkg::MODE_4BPP: active = (LANE < 2);
      default:              active = (LANE == 0);
    endcase
  end

  always_comb begin
    if (masked_row && mask_bit) begin
      pix = cfg.trans_idx;
    end else if (masked_row && (raw == cfg.trans_idx)) begin
      pix = cfg.opaque_idx;
    end else begin
      pix = raw;
    end
  end

  // Full-precision column test, so a column past the width still ends the row
  assign col_next = {1'b0, column} + (gifpu_pkg::DIM_W + 1)'(LANE + 1);
  assign row_end  = (col_next >= {1'b0, cfg.width});

  assign lane_out = '{pix: pix, row_end: row_end, active: active};

endmodule

// ===== hw/rtl/gifpu_merge.sv =====
module gifpu_merge (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gifpu_pkg::cfg_t             cfg,
  input  logic                        accept,
  input  logic [gifpu_pkg::PIX_W-1:0] data_byte,
  input  logic [gifpu_pkg::LANES-1:0] mask_bits,
  input  logic                        mask_present,
  output gifpu_pkg::batch_t           batch
);

  logic [gifpu_pkg::DIM_W-1:0] column_r, column_nxt;
  logic [gifpu_pkg::DIM_W-1:0] row_r, row_nxt;
  gifpu_pkg::pass_t            pass_r, pass_nxt;

  gifpu_pkg::mode_t            mode;
  logic [gifpu_pkg::LANE_W:0]  n_pix;
  logic                        masked_row;
  gifpu_pkg::lane_out_t        lane_out [gifpu_pkg::LANES];

  logic [gifpu_pkg::LANES-1:0][gifpu_pkg::PIX_W-1:0] pix;
  logic [gifpu_pkg::LANE_W-1:0]                      last_idx;
  logic                                              row_done;

  assign mode       = gifpu_pkg::bpp_mode(cfg.bpp);
  assign n_pix      = gifpu_pkg::per_byte(mode);
  assign masked_row = mask_present && cfg.trans_on;

  for (genvar k = 0; k < gifpu_pkg::LANES; k++) begin : g_lane
    gifpu_lane #(.LANE(k)) u_lane (
      .data_byte  (data_byte),
      .mask_bit   (mask_bits[gifpu_pkg::LANES-1-k]),
      .masked_row (masked_row),
      .mode       (mode),
      .column     (column_r),
      .cfg        (cfg),
      .lane_out   (lane_out[k])
    );
    assign pix[k] = lane_out[k].pix;
  end

  // Cut the byte at the first active lane that ends the row
  always_comb begin
    last_idx = gifpu_pkg::LANE_W'(n_pix - 1'b1);
    row_done = 1'b0;
    for (int k = gifpu_pkg::LANES - 1; k >= 0; k--) begin
      if (lane_out[k].active && lane_out[k].row_end) begin
        last_idx = gifpu_pkg::LANE_W'(k);
        row_done = 1'b1;
      end
    end
  end

  assign batch = '{pix: pix, row: row_r, last_idx: last_idx, row_done: row_done};

  always_comb begin
    if (row_done) begin
      column_nxt = '0;
    end else begin
      column_nxt = column_r + gifpu_pkg::DIM_W'(n_pix);
    end
  end

  // Row advance: plain +1, or along the four interlace passes
  always_comb begin
    logic [3:0]                  step;
    logic [gifpu_pkg::DIM_W:0]   sum;
    logic                        il;
    row_nxt  = row_r;
    pass_nxt = pass_r;
    il       = cfg.interlaced && (cfg.height >= gifpu_pkg::MIN_IL_HEIGHT);
    unique case (pass_r)
      gifpu_pkg::PASS_0: step = gifpu_pkg::STEP_P0;
      gifpu_pkg::PASS_1: step = gifpu_pkg::STEP_P1;
      gifpu_pkg::PASS_2: step = gifpu_pkg::STEP_P2;
      default:           step = gifpu_pkg::STEP_P3;
    endcase
    sum = {1'b0, row_r} + (gifpu_pkg::DIM_W + 1)'(step);
    if (!il) begin
      row_nxt = row_r + 1'b1;
    end else if (pass_r == gifpu_pkg::PASS_3) begin
      row_nxt = sum[gifpu_pkg::DIM_W-1:0];
    end else if (sum >= {1'b0, cfg.height}) begin
      unique case (pass_r)
        gifpu_pkg::PASS_0: begin
          row_nxt  = gifpu_pkg::START_P1;
          pass_nxt = gifpu_pkg::PASS_1;
        end
        gifpu_pkg::PASS_1: begin
          row_nxt  = gifpu_pkg::START_P2;
          pass_nxt = gifpu_pkg::PASS_2;
        end
        default: begin
          row_nxt  = gifpu_pkg::START_P3;
          pass_nxt = gifpu_pkg::PASS_3;
        end
      endcase
    end else begin
      row_nxt = sum[gifpu_pkg::DIM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r <= '0;
      row_r    <= '0;
      pass_r   <= gifpu_pkg::PASS_0;
    end else if (accept) begin
      column_r <= column_nxt;
      if (row_done) begin
        row_r  <= row_nxt;
        pass_r <= pass_nxt;
      end
    end
  end

endmodule

// ===== hw/rtl/gifpu_ser.sv =====
`include "gif_pixel_unpack_and_interlace_macros.svh"

module gifpu_ser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  gifpu_pkg::batch_t           batch_in,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [gifpu_pkg::PIX_W-1:0] pixel_index,
  output logic [gifpu_pkg::DIM_W-1:0] row_number,
  output logic                        row_done,
  output logic                        last_of_byte
);

  gifpu_pkg::batch_t              batch_r;
  logic                           full_r;
  logic [gifpu_pkg::LANE_W-1:0]   idx_r;
  logic                           take;
  logic                           at_last;
  logic                           drain_last;
  logic                           load;

  assign at_last    = (idx_r == batch_r.last_idx);
  assign take       = full_r && out_ready;
  assign drain_last = take && at_last;
  // Take the next byte in the same cycle its predecessor's last pixel leaves
  assign in_ready   = !full_r || drain_last;
  assign load       = in_valid && in_ready;

  assign out_valid    = full_r;
  assign pixel_index  = batch_r.pix[idx_r];
  assign row_number   = batch_r.row;
  assign row_done     = batch_r.row_done && at_last;
  assign last_of_byte = at_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      idx_r  <= '0;
    end else if (load) begin
      full_r <= 1'b1;
      idx_r  <= '0;
    end else if (drain_last) begin
      full_r <= 1'b0;
    end else if (take) begin
      idx_r  <= idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      batch_r <= batch_in;
    end
  end

  `GIFPU_ASSERT_NEXT(a_load_starts, clk, rst_n, load, full_r && (idx_r == '0), "load did not restart the drain")
  `GIFPU_ASSERT_NOW(a_idx_in_range, clk, rst_n, full_r, idx_r <= batch_r.last_idx, "drain index ran past the byte")
  `GIFPU_ASSERT_NEXT(a_no_early_drop, clk, rst_n, take && !at_last, full_r, "byte dropped before its last pixel")
  `GIFPU_ASSERT_NOW(a_no_load_midbyte, clk, rst_n, full_r && !drain_last, !in_ready, "request taken while a byte is draining")

endmodule

// ===== dv/gifpu_pixel_checker.sv =====
module gifpu_pixel_checker
  import gifpu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  gifpu_in_if               in_mon,
  gifpu_out_if              out_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic              pready,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic [DIM_W-1:0] row;
    logic             row_done;
    logic             last_of_byte;
  } pixel_exp_t;

  cfg_t             regs;
  logic [DIM_W-1:0] column;
  logic [DIM_W-1:0] cur_row;
  pass_t            pass_no;
  pixel_exp_t       pixels_due[$];

  // Height test is done on the unclipped sum, before the row is stored
  function automatic void advance_row();
    logic [DIM_W:0] sum;
    if (regs.interlaced && regs.height >= 16'd5) begin
      case (pass_no)
        PASS_0: begin
          sum = {1'b0, cur_row} + 17'd8;
          if (sum >= {1'b0, regs.height}) begin
            cur_row = 16'd4;
            pass_no = PASS_1;
          end else begin
            cur_row = sum[DIM_W-1:0];
          end
        end
        PASS_1: begin
          sum = {1'b0, cur_row} + 17'd8;
          if (sum >= {1'b0, regs.height}) begin
            cur_row = 16'd2;
            pass_no = PASS_2;
          end else begin
            cur_row = sum[DIM_W-1:0];
          end
        end
        PASS_2: begin
          sum = {1'b0, cur_row} + 17'd4;
          if (sum >= {1'b0, regs.height}) begin
            cur_row = 16'd1;
            pass_no = PASS_3;
          end else begin
            cur_row = sum[DIM_W-1:0];
          end
        end
        default: cur_row = cur_row + 16'd2;
      endcase
    end else begin
      cur_row = cur_row + 16'd1;
    end
  endfunction

  function automatic void unpack_byte(input logic [7:0] d, input logic [7:0] m,
                                      input logic mp);
    int         depth;
    int         lanes;
    logic [7:0] pix;
    logic       row_end;
    logic       masked;
    pixel_exp_t e;
    masked = mp && regs.trans_on;
    // any depth other than 1 or 4 unpacks as 8
    case (regs.bpp)
      4'd1: begin
        depth = 1;
        lanes = 8;
      end
      4'd4: begin
        depth = 4;
        lanes = 2;
      end
      default: begin
        depth = 8;
        lanes = 1;
      end
    endcase
    for (int k = 0; k < lanes; k++) begin
      pix = 8'((d >> (8 - depth * (k + 1))) & ((1 << depth) - 1));
      row_end = ({1'b0, column} + 17'd1) >= {1'b0, regs.width};
      if (masked) begin
        if (m[7-k]) begin
          pix = regs.trans_idx;
        end else if (pix == regs.trans_idx) begin
          pix = regs.opaque_idx;
        end
      end
      e.pix = pix;
      e.row = cur_row;
      e.row_done = row_end;
      e.last_of_byte = row_end || (k == lanes - 1);
      pixels_due.push_back(e);
      // drop the rest of the byte once the row is complete
      if (row_end) begin
        column = '0;
        advance_row();
        break;
      end
      column = column + 16'd1;
    end
  endfunction

  always @(posedge clk) begin : watch
    pixel_exp_t want;
    logic       bad;
    if (!rst_n) begin
      regs.bpp = BPP_RST;
      regs.width = WIDTH_RST;
      regs.height = HEIGHT_RST;
      regs.trans_on = 1'b0;
      regs.trans_idx = '0;
      regs.opaque_idx = '0;
      regs.interlaced = 1'b0;
      column = '0;
      cur_row = '0;
      pass_no = PASS_0;
      pixels_due.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_BPP:        regs.bpp = pwdata[BPP_W-1:0];
          REG_WIDTH:      regs.width = pwdata[DIM_W-1:0];
          REG_HEIGHT:     regs.height = pwdata[DIM_W-1:0];
          REG_TRANS_ON:   regs.trans_on = pwdata[0];
          REG_TRANS_IDX:  regs.trans_idx = pwdata[PIX_W-1:0];
          REG_OPAQUE_IDX: regs.opaque_idx = pwdata[PIX_W-1:0];
          REG_INTERLACED: regs.interlaced = pwdata[0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pixels_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected pixel: pix %h row %0d done %b last %b",
                     out_mon.pixel_index, out_mon.row_number, out_mon.row_done,
                     out_mon.last_of_byte);
          end
        end else begin
          want = pixels_due.pop_front();
          bad = (want.pix !== out_mon.pixel_index) || (want.row !== out_mon.row_number)
                || (want.row_done !== out_mon.row_done)
                || (want.last_of_byte !== out_mon.last_of_byte);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("pixel wrong: exp pix %h row %0d done %b last %b", want.pix,
                       want.row, want.row_done, want.last_of_byte);
              $display("             got pix %h row %0d done %b last %b",
                       out_mon.pixel_index, out_mon.row_number, out_mon.row_done,
                       out_mon.last_of_byte);
            end
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        unpack_byte(in_mon.data_byte, in_mon.mask_bits, in_mon.mask_present);
      end
    end
    pending = pixels_due.size();
  end

endmodule

// ===== dv/tb_gif_pixel_unpack_and_interlace.sv =====
module tb_gif_pixel_unpack_and_interlace;
  import gifpu_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                pending;
  int                cycles;
  bit                quiet_run;
  bit                hold_req;

  gifpu_in_if  in_chan ();
  gifpu_out_if out_chan ();

  gif_pixel_unpack_and_interlace u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  gifpu_pixel_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pixel receiver: random stalls, plus one long hold on request
  initial begin : receiver
    int hold;
    bit hold_taken;
    hold = 0;
    hold_taken = 1'b0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold = HOLD_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold > 0) begin
        hold--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= quiet_run || ($urandom_range(99) >= 6);
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'(4 * int'(idx));
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_cfg(input cfg_t c);
    write_reg(REG_BPP, APB_DW'(c.bpp));
    write_reg(REG_WIDTH, APB_DW'(c.width));
    write_reg(REG_HEIGHT, APB_DW'(c.height));
    write_reg(REG_TRANS_ON, APB_DW'(c.trans_on));
    write_reg(REG_TRANS_IDX, APB_DW'(c.trans_idx));
    write_reg(REG_OPAQUE_IDX, APB_DW'(c.opaque_idx));
    write_reg(REG_INTERLACED, APB_DW'(c.interlaced));
  endtask

  // Called on a falling edge; returns on the falling edge after acceptance
  task automatic send_byte(input logic [7:0] d, input logic [7:0] m, input logic mp);
    if (!quiet_run && $urandom_range(99) < 6) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= d;
    in_chan.mask_bits <= m;
    in_chan.mask_present <= mp;
    do @(posedge clk); while (!in_chan.ready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic cfg_t random_cfg();
    cfg_t r;
    case ($urandom_range(9))
      0:       r.bpp = 4'($urandom);
      1, 2, 3: r.bpp = 4'd1;
      4, 5, 6: r.bpp = 4'd4;
      default: r.bpp = 4'd8;
    endcase
    r.width = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(1, 24));
    case ($urandom_range(9))
      0:       r.height = 16'($urandom);
      1:       r.height = 16'($urandom_range(0, 4));
      default: r.height = 16'($urandom_range(5, 40));
    endcase
    r.trans_on = $urandom_range(99) < 70;
    // favour small indices so that they collide with 1- and 4-bit pixels
    case ($urandom_range(2))
      0:       r.trans_idx = 8'($urandom_range(0, 1));
      1:       r.trans_idx = 8'($urandom_range(0, 15));
      default: r.trans_idx = 8'($urandom);
    endcase
    r.opaque_idx = 8'($urandom);
    r.interlaced = $urandom_range(3) != 0;
    return r;
  endfunction

  initial begin : stimulus
    cfg_t c;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.mask_bits = '0;
    in_chan.mask_present = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    quiet_run = 1'b0;
    hold_req = 1'b0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // defaults after reset: 8 bits per pixel, one pixel per row
    send_byte(8'h00, 8'h00, 1'b0);
    send_byte(8'hFF, 8'hFF, 1'b1);
    settle();

    // 1 bit per pixel; height below 5 so interlace is ignored
    c = '{bpp: 4'd1, width: 16'd20, height: 16'd4, trans_on: 1'b1,
          trans_idx: 8'd1, opaque_idx: 8'd0, interlaced: 1'b1};
    load_cfg(c);
    send_byte(8'hFF, 8'h00, 1'b1);
    send_byte(8'h00, 8'hFF, 1'b1);
    send_byte(8'hA5, 8'h5A, 1'b0);
    send_byte(8'hC3, 8'h3C, 1'b1);
    send_byte(8'h5A, 8'hA5, 1'b1);
    settle();
    // shrink the width under the current column
    c.width = 16'd8;
    load_cfg(c);
    send_byte(8'h81, 8'h18, 1'b1);
    settle();

    // unused depth, zero width, all four passes and beyond
    c = '{bpp: 4'd15, width: 16'd0, height: 16'd5, trans_on: 1'b1,
          trans_idx: 8'hFF, opaque_idx: 8'h00, interlaced: 1'b1};
    load_cfg(c);
    send_byte(8'hFF, 8'h00, 1'b1);
    send_byte(8'h80, 8'h80, 1'b1);
    send_byte(8'hFF, 8'h80, 1'b0);
    send_byte(8'h00, 8'h00, 1'b1);
    send_byte(8'h7F, 8'hFF, 1'b1);
    send_byte(8'h01, 8'h7F, 1'b1);
    send_byte(8'hFE, 8'h00, 1'b1);
    send_byte(8'hFF, 8'hFF, 1'b0);
    settle();

    c = '{bpp: 4'd4, width: 16'd3, height: 16'hFFFF, trans_on: 1'b1,
          trans_idx: 8'h0F, opaque_idx: 8'hF0, interlaced: 1'b0};
    load_cfg(c);
    send_byte(8'hF0, 8'h40, 1'b1);
    send_byte(8'h0F, 8'h80, 1'b1);
    send_byte(8'h3C, 8'hC0, 1'b0);
    send_byte(8'hFF, 8'h00, 1'b1);
    settle();

    c = '{bpp: 4'd0, width: 16'hFFFF, height: 16'd1, trans_on: 1'b0,
          trans_idx: 8'hAA, opaque_idx: 8'h55, interlaced: 1'b0};
    load_cfg(c);
    send_byte(8'h55, 8'hAA, 1'b1);
    send_byte(8'hAA, 8'h55, 1'b0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      c = random_cfg();
      load_cfg(c);
      quiet_run = (ph == 3) || (ph == 4);
      // hold the receiver while requests keep coming
      if (ph == 1) hold_req = 1'b1;
      repeat (17) send_byte(8'($urandom), 8'($urandom), $urandom_range(99) < 70);
      settle();
    end

    repeat (16) @(negedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
